@@ rtl/core/broyden_jacobian_update_macros.svh @@
// Assertion macros shared by the Broyden update checker
`ifndef BROYDEN_JACOBIAN_UPDATE_MACROS_SVH
`define BROYDEN_JACOBIAN_UPDATE_MACROS_SVH

// Antecedent in this cycle implies consequent in the next cycle
`define BJR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle
`define BJR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/bjr_pkg.sv @@
// Shared types, constants and helpers for the Broyden Jacobian update block
package bjr_pkg;

    localparam int DEF_MAX_DIMS  = 8;
    localparam int DEF_MAX_OBS   = 64;
    localparam int DEF_FRAC_BITS = 16;

    localparam int FUNC_W     = 3;
    localparam int DIM_IDX_W  = 3;
    localparam int OBS_IDX_W  = 6;
    localparam int DATA_W     = 32;
    localparam int WIDE_W     = 64;
    localparam int DIMS_CFG_W = 4;
    localparam int OBS_CFG_W  = 7;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 1;

    // Request function codes
    localparam logic [FUNC_W-1:0] FN_LOAD_JAC = 3'd0;
    localparam logic [FUNC_W-1:0] FN_LOAD_STEP = 3'd1;
    localparam logic [FUNC_W-1:0] FN_LOAD_RES = 3'd2;
    localparam logic [FUNC_W-1:0] FN_UPDATE = 3'd3;
    localparam logic [FUNC_W-1:0] FN_READ_JAC = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIMS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OBS  = 1'd1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_ZERO  = 2'd1,
        ST_SAT   = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        RES_NONE,
        RES_ITEM,
        RES_READ,
        RES_ZERO,
        RES_UPDATE
    } res_t;

    typedef enum logic [1:0] {
        MS_STEP,
        MS_JAC,
        MS_CORR
    } mul_src_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_SQ_MUL,
        S_SQ_ACC,
        S_SQ_CHK,
        S_COL_RD,
        S_COL_MUL,
        S_COL_ACC,
        S_COL_WR,
        S_ROW_RD,
        S_ROW_MUL,
        S_ROW_DLD,
        S_ROW_DIV,
        S_ROW_WR,
        S_FINISH
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic     capture;
        logic     item_addr;
        logic     exec_item;
        logic     mul_en;
        mul_src_t mul_src;
        logic     s_clr;
        logic     sq_acc;
        logic     acc_clr;
        logic     col_acc;
        logic     col_wr;
        logic     div_start;
        logic     row_wr;
        logic     i_clr;
        logic     i_inc;
        logic     j_clr;
        logic     j_inc;
        res_t     result;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              dim_ok;
        logic              obs_ok;
        logic              last_i;
        logic              last_j;
        logic              s_zero;
        logic              div_done;
    } stat_t;

    // Magnitude of a signed word as an unsigned word
    function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] v);
        mag32 = v[DATA_W-1] ? (~v + 1'b1) : v;
    endfunction

    // Clamp a wide signed value into 32 bits
    function automatic logic [DATA_W:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = 64'sh0000_0000_7FFF_FFFF;
        lo = -64'sh0000_0000_8000_0000;
        if (v > hi)
            sat32 = {1'b1, 32'h7FFF_FFFF};
        else if (v < lo)
            sat32 = {1'b1, 32'h8000_0000};
        else
            sat32 = {1'b0, v[DATA_W-1:0]};
    endfunction

endpackage

@@ rtl/core/broyden_jacobian_update.sv @@
// Loads, out-of-range and unused requests give their result from the execute state through
// the result register; reads pass through the read state as well. An update runs the
// bit-serial 64-bit divider once per Jacobian entry in use (D rows, O columns).
// One request at a time; busy is high while one is in work and the next may start
// in the cycle its result shows.
// Reset clears control and config (8 rows, 64 columns); stores are undefined until written.
module broyden_jacobian_update #(
    parameter int MAX_DIMS  = bjr_pkg::DEF_MAX_DIMS,
    parameter int MAX_OBS   = bjr_pkg::DEF_MAX_OBS,
    parameter int FRAC_BITS = bjr_pkg::DEF_FRAC_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    output logic                           done,
    input  logic                           cfg_write,
    input  logic [bjr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bjr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [bjr_pkg::FUNC_W-1:0]     func,
    input  logic [bjr_pkg::DIM_IDX_W-1:0]  dim_index,
    input  logic [bjr_pkg::OBS_IDX_W-1:0]  obs_index,
    input  logic signed [bjr_pkg::DATA_W-1:0] jacobian_value,
    input  logic signed [bjr_pkg::DATA_W-1:0] step_value,
    input  logic signed [bjr_pkg::DATA_W-1:0] new_residual,
    input  logic signed [bjr_pkg::DATA_W-1:0] old_residual,
    output logic [1:0]                     status,
    output logic signed [bjr_pkg::DATA_W-1:0] read_value
);
    import bjr_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    bjr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    bjr_dp #(
        .MAX_DIMS  (MAX_DIMS),
        .MAX_OBS   (MAX_OBS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .func           (func),
        .dim_index      (dim_index),
        .obs_index      (obs_index),
        .jacobian_value (jacobian_value),
        .step_value     (step_value),
        .new_residual   (new_residual),
        .old_residual   (old_residual),
        .cmd            (cmd),
        .stat           (stat),
        .done           (done),
        .status         (status),
        .read_value     (read_value)
    );

endmodule

@@ rtl/core/bjr_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle
module bjr_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [bjr_pkg::WIDE_W-1:0] dividend,
    input  logic [bjr_pkg::WIDE_W-1:0] divisor,
    output logic                       done,
    output logic [bjr_pkg::WIDE_W-1:0] quotient
);
    import bjr_pkg::*;

    localparam int CNT_W = $clog2(WIDE_W);

    logic              run_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [WIDE_W-1:0] rem_reg;
    logic [WIDE_W-1:0] quo_reg;
    logic [WIDE_W:0]   shifted;
    logic [WIDE_W:0]   trial;

    // Trial subtract of the shifted remainder
    assign shifted = {rem_reg, quo_reg[WIDE_W-1]};
    assign trial   = shifted - {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= run_reg && (cnt_reg == CNT_W'(WIDE_W - 1));
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(WIDE_W - 1))
                    run_reg <= 1'b0;
            end
        end
    end

    // Remainder and quotient shift
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (run_reg)
        begin
            if (!trial[WIDE_W])
            begin
                rem_reg <= trial[WIDE_W-1:0];
                quo_reg <= {quo_reg[WIDE_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[WIDE_W-1:0];
                quo_reg <= {quo_reg[WIDE_W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ rtl/core/bjr_ctrl.sv @@
// Sequencer for requests and the rank-one update
module bjr_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  bjr_pkg::stat_t stat,
    output logic           busy,
    output bjr_pkg::cmd_t  cmd
);
    import bjr_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (start)
                    state_next = S_EXEC;
            S_EXEC:
                if (stat.func == FN_UPDATE)
                    state_next = S_SQ_MUL;
                else if (stat.func == FN_READ_JAC && stat.dim_ok && stat.obs_ok)
                    state_next = S_READ;
                else
                    state_next = S_IDLE;
            S_READ:    state_next = S_IDLE;
            S_SQ_MUL:  state_next = S_SQ_ACC;
            S_SQ_ACC:  state_next = stat.last_i ? S_SQ_CHK : S_SQ_MUL;
            S_SQ_CHK:  state_next = stat.s_zero ? S_IDLE : S_COL_RD;
            S_COL_RD:  state_next = S_COL_MUL;
            S_COL_MUL: state_next = S_COL_ACC;
            S_COL_ACC: state_next = stat.last_i ? S_COL_WR : S_COL_RD;
            S_COL_WR:  state_next = stat.last_j ? S_ROW_RD : S_COL_RD;
            S_ROW_RD:  state_next = S_ROW_MUL;
            S_ROW_MUL: state_next = S_ROW_DLD;
            S_ROW_DLD: state_next = S_ROW_DIV;
            S_ROW_DIV:
                if (stat.div_done)
                    state_next = S_ROW_WR;
            S_ROW_WR:
                if (stat.last_j && stat.last_i)
                    state_next = S_FINISH;
                else
                    state_next = S_ROW_RD;
            S_FINISH:  state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd = '0;
        cmd.mul_src = MS_STEP;
        cmd.result  = RES_NONE;
        unique case (state_reg)
            S_IDLE:
                cmd.capture = start;
            S_EXEC:
            begin
                cmd.item_addr = 1'b1;
                cmd.exec_item = 1'b1;
                if (stat.func == FN_UPDATE)
                begin
                    cmd.s_clr = 1'b1;
                    cmd.i_clr = 1'b1;
                end
                else if (!(stat.func == FN_READ_JAC && stat.dim_ok && stat.obs_ok))
                    cmd.result = RES_ITEM;
            end
            S_READ:
                cmd.result = RES_READ;
            S_SQ_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_src = MS_STEP;
            end
            S_SQ_ACC:
            begin
                cmd.sq_acc = 1'b1;
                if (stat.last_i)
                begin
                    cmd.i_clr = 1'b1;
                    cmd.j_clr = 1'b1;
                end
                else
                    cmd.i_inc = 1'b1;
            end
            S_SQ_CHK:
            begin
                cmd.acc_clr = 1'b1;
                if (stat.s_zero)
                    cmd.result = RES_ZERO;
            end
            S_COL_RD: ;
            S_COL_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_src = MS_JAC;
            end
            S_COL_ACC:
            begin
                cmd.col_acc = 1'b1;
                if (!stat.last_i)
                    cmd.i_inc = 1'b1;
            end
            S_COL_WR:
            begin
                cmd.col_wr  = 1'b1;
                cmd.acc_clr = 1'b1;
                cmd.i_clr   = 1'b1;
                if (stat.last_j)
                    cmd.j_clr = 1'b1;
                else
                    cmd.j_inc = 1'b1;
            end
            S_ROW_RD: ;
            S_ROW_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_src = MS_CORR;
            end
            S_ROW_DLD:
                cmd.div_start = 1'b1;
            S_ROW_DIV: ;
            S_ROW_WR:
            begin
                cmd.row_wr = 1'b1;
                if (stat.last_j)
                begin
                    cmd.j_clr = 1'b1;
                    cmd.i_inc = !stat.last_i;
                end
                else
                    cmd.j_inc = 1'b1;
            end
            S_FINISH:
                cmd.result = RES_UPDATE;
            default: ;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

@@ rtl/core/bjr_dp.sv @@
// Stores, shared multiplier, accumulators and result registers
module bjr_dp #(
    parameter int MAX_DIMS  = bjr_pkg::DEF_MAX_DIMS,
    parameter int MAX_OBS   = bjr_pkg::DEF_MAX_OBS,
    parameter int FRAC_BITS = bjr_pkg::DEF_FRAC_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [bjr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bjr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [bjr_pkg::FUNC_W-1:0]     func,
    input  logic [bjr_pkg::DIM_IDX_W-1:0]  dim_index,
    input  logic [bjr_pkg::OBS_IDX_W-1:0]  obs_index,
    input  logic signed [bjr_pkg::DATA_W-1:0] jacobian_value,
    input  logic signed [bjr_pkg::DATA_W-1:0] step_value,
    input  logic signed [bjr_pkg::DATA_W-1:0] new_residual,
    input  logic signed [bjr_pkg::DATA_W-1:0] old_residual,
    input  bjr_pkg::cmd_t                  cmd,
    output bjr_pkg::stat_t                 stat,
    output logic                           done,
    output logic [1:0]                     status,
    output logic signed [bjr_pkg::DATA_W-1:0] read_value
);
    import bjr_pkg::*;

    localparam int DEPTH = MAX_DIMS * MAX_OBS;
    localparam int I_W   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int J_W   = (MAX_OBS > 1) ? $clog2(MAX_OBS) : 1;
    localparam int A_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Configuration
    logic [DIMS_CFG_W-1:0] dims_reg;
    logic [OBS_CFG_W-1:0]  obs_cfg_reg;
    logic [31:0]           eff_dims;
    logic [31:0]           eff_obs;

    // Captured request
    logic [FUNC_W-1:0]    func_reg;
    logic [DIM_IDX_W-1:0] dim_reg;
    logic [OBS_IDX_W-1:0] obs_reg;
    logic [DATA_W-1:0]    jv_reg;
    logic [DATA_W-1:0]    sv_reg;
    logic [DATA_W-1:0]    nr_reg;
    logic [DATA_W-1:0]    or_reg;

    logic dim_ok;
    logic obs_ok;
    logic [31:0] dim32;
    logic [31:0] obs32;

    // Counters
    logic [I_W-1:0] i_reg;
    logic [J_W-1:0] j_reg;

    // Stores
    logic [DATA_W-1:0] jac_mem [DEPTH];
    logic [DATA_W-1:0] res_mem [MAX_OBS];
    logic [DATA_W-1:0] corr_mem [MAX_OBS];
    logic [DATA_W-1:0] step_reg [MAX_DIMS];
    logic [DATA_W-1:0] jac_rd_reg;
    logic [DATA_W-1:0] res_rd_reg;
    logic [DATA_W-1:0] corr_rd_reg;

    logic [31:0]       addr32;
    logic [A_W-1:0]    jac_addr;
    logic              jac_we;
    logic [DATA_W-1:0] jac_wdata;
    logic              res_we;
    logic [DATA_W-1:0] h_cur;

    // Arithmetic
    logic [DATA_W-1:0]        mul_a;
    logic [WIDE_W-1:0]        mul_reg;
    logic                     neg_reg;
    logic [WIDE_W-1:0]        s_reg;
    logic signed [WIDE_W-1:0] acc_reg;
    logic [DATA_W-1:0]        e_reg;
    logic                     sat_reg;
    logic [WIDE_W-1:0]        shifted;
    logic [DATA_W:0]          res_sat;
    logic [DATA_W:0]          col_sat;
    logic [DATA_W:0]          row_sat;
    logic signed [WIDE_W-1:0] inc;
    logic                     div_done;
    logic [WIDE_W-1:0]        quo;
    status_t                  item_status;

    // Result registers
    logic              done_reg;
    status_t           status_reg;
    logic [DATA_W-1:0] rv_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg    <= DIMS_CFG_W'(8);
            obs_cfg_reg <= OBS_CFG_W'(64);
        end
        else if (cfg_write)
        begin
            if (cfg_index == CFG_DIMS)
                dims_reg <= cfg_data[DIMS_CFG_W-1:0];
            else if (cfg_index == CFG_OBS)
                obs_cfg_reg <= cfg_data[OBS_CFG_W-1:0];
        end
    end

    // Clamp counts into 1..max
    always_comb
    begin
        if (dims_reg == '0)
            eff_dims = 32'd1;
        else if (32'(dims_reg) > 32'(MAX_DIMS))
            eff_dims = 32'(MAX_DIMS);
        else
            eff_dims = 32'(dims_reg);
        if (obs_cfg_reg == '0)
            eff_obs = 32'd1;
        else if (32'(obs_cfg_reg) > 32'(MAX_OBS))
            eff_obs = 32'(MAX_OBS);
        else
            eff_obs = 32'(obs_cfg_reg);
    end

    // Request capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= func;
            dim_reg  <= dim_index;
            obs_reg  <= obs_index;
            jv_reg   <= jacobian_value;
            sv_reg   <= step_value;
            nr_reg   <= new_residual;
            or_reg   <= old_residual;
        end
    end

    assign dim32  = 32'(dim_reg);
    assign obs32  = 32'(obs_reg);
    assign dim_ok = dim32 < eff_dims;
    assign obs_ok = obs32 < eff_obs;

    // Loop counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg <= '0;
            j_reg <= '0;
        end
        else
        begin
            if (cmd.i_clr)
                i_reg <= '0;
            else if (cmd.i_inc)
                i_reg <= i_reg + 1'b1;
            if (cmd.j_clr)
                j_reg <= '0;
            else if (cmd.j_inc)
                j_reg <= j_reg + 1'b1;
        end
    end

    // Jacobian address: request or loop position
    assign addr32 = cmd.item_addr ? (dim32 * 32'(MAX_OBS) + obs32)
                                  : (32'(i_reg) * 32'(MAX_OBS) + 32'(j_reg));
    assign jac_addr = addr32[A_W-1:0];

    assign res_sat = sat32(64'($signed(nr_reg)) - 64'($signed(or_reg)));
    assign col_sat = sat32(64'($signed(res_rd_reg)) - acc_reg);
    assign inc     = neg_reg ? -$signed(quo) : $signed(quo);
    assign row_sat = sat32(64'($signed(e_reg)) + inc);

    assign jac_we = (cmd.exec_item && func_reg == FN_LOAD_JAC && dim_ok && obs_ok)
                    || cmd.row_wr;
    assign jac_wdata = cmd.row_wr ? row_sat[DATA_W-1:0] : jv_reg;
    assign res_we = cmd.exec_item && func_reg == FN_LOAD_RES && obs_ok;

    // Jacobian store
    always_ff @(posedge clk)
    begin
        if (jac_we)
            jac_mem[jac_addr] <= jac_wdata;
        jac_rd_reg <= jac_mem[jac_addr];
    end

    // Residual difference store
    always_ff @(posedge clk)
    begin
        if (res_we)
            res_mem[obs32[J_W-1:0]] <= res_sat[DATA_W-1:0];
        res_rd_reg <= res_mem[j_reg];
    end

    // Correction store
    always_ff @(posedge clk)
    begin
        if (cmd.col_wr)
            corr_mem[j_reg] <= col_sat[DATA_W-1:0];
        corr_rd_reg <= corr_mem[j_reg];
    end

    // Step vector
    always_ff @(posedge clk)
    begin
        if (cmd.exec_item && func_reg == FN_LOAD_STEP && dim_ok)
            step_reg[dim32[I_W-1:0]] <= sv_reg;
    end

    assign h_cur = step_reg[i_reg];

    // Shared multiplier on magnitudes
    always_comb
    begin
        unique case (cmd.mul_src)
            MS_STEP: mul_a = h_cur;
            MS_JAC:  mul_a = jac_rd_reg;
            MS_CORR: mul_a = corr_rd_reg;
            default: mul_a = h_cur;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            mul_reg <= 64'(mag32(mul_a)) * 64'(mag32(h_cur));
            neg_reg <= mul_a[DATA_W-1] ^ h_cur[DATA_W-1];
            e_reg   <= jac_rd_reg;
        end
    end

    assign shifted = mul_reg >> FRAC_BITS;

    // Squared step length and J*h accumulators
    always_ff @(posedge clk)
    begin
        if (cmd.s_clr)
            s_reg <= '0;
        else if (cmd.sq_acc)
            s_reg <= s_reg + shifted;
        if (cmd.acc_clr)
            acc_reg <= '0;
        else if (cmd.col_acc)
            acc_reg <= neg_reg ? acc_reg - $signed(shifted) : acc_reg + $signed(shifted);
    end

    // Sticky saturation flag for the update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sat_reg <= 1'b0;
        else if (cmd.s_clr)
            sat_reg <= 1'b0;
        else if ((cmd.col_wr && col_sat[DATA_W]) || (cmd.row_wr && row_sat[DATA_W]))
            sat_reg <= 1'b1;
    end

    bjr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (mul_reg),
        .divisor  (s_reg),
        .done     (div_done),
        .quotient (quo)
    );

    // Status of a single-step request
    always_comb
    begin
        unique case (func_reg)
            FN_LOAD_JAC:  item_status = (dim_ok && obs_ok) ? ST_OK : ST_RANGE;
            FN_LOAD_STEP: item_status = dim_ok ? ST_OK : ST_RANGE;
            FN_LOAD_RES:  item_status = !obs_ok ? ST_RANGE : (res_sat[DATA_W] ? ST_SAT : ST_OK);
            FN_READ_JAC:  item_status = ST_RANGE;
            default:      item_status = ST_OK;
        endcase
    end

    // Result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg   <= 1'b0;
            status_reg <= ST_OK;
            rv_reg     <= '0;
        end
        else
        begin
            done_reg <= (cmd.result != RES_NONE);
            unique case (cmd.result)
                RES_NONE: ;
                RES_ITEM:
                begin
                    status_reg <= item_status;
                    rv_reg     <= '0;
                end
                RES_READ:
                begin
                    status_reg <= ST_OK;
                    rv_reg     <= jac_rd_reg;
                end
                RES_ZERO:
                begin
                    status_reg <= ST_ZERO;
                    rv_reg     <= '0;
                end
                RES_UPDATE:
                begin
                    status_reg <= sat_reg ? ST_SAT : ST_OK;
                    rv_reg     <= '0;
                end
                default: ;
            endcase
        end
    end

    assign stat.func     = func_reg;
    assign stat.dim_ok   = dim_ok;
    assign stat.obs_ok   = obs_ok;
    assign stat.last_i   = (32'(i_reg) == eff_dims - 32'd1);
    assign stat.last_j   = (32'(j_reg) == eff_obs - 32'd1);
    assign stat.s_zero   = (s_reg == '0);
    assign stat.div_done = div_done;

    assign done       = done_reg;
    assign status     = status_reg;
    assign read_value = rv_reg;

endmodule

@@ rtl/core/bjr_checker.sv @@
// Port-level checks for the Broyden update block, bound to the top level
`include "broyden_jacobian_update_macros.svh"

module bjr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [1:0]  status,
    input logic [31:0] read_value
);
    import bjr_pkg::*;

    // An accepted request makes the block busy in the next cycle
    `BJR_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request not busy")
    // No result in the cycle right after acceptance
    `BJR_ASSERT_NEXT(a_accept_no_done, start && !busy, !done, "result too early")
    // Results never come back to back
    `BJR_ASSERT_NEXT(a_done_single, done, !done, "results back to back")
    // Only an ok result can carry read data
    `BJR_ASSERT_SAME(a_value_zero, done && status != ST_OK, read_value == '0, "stray read data")

endmodule

bind broyden_jacobian_update bjr_checker u_bjr_checker (.*);

@@ sim/tb.sv @@
// Self-checking testbench for the Broyden rank-one Jacobian update block
module tb;
    import bjr_pkg::*;

    localparam int LIMIT_CYCLES = 4_000_000;
    localparam int NUM_DIMS     = DEF_MAX_DIMS;
    localparam int NUM_OBS      = DEF_MAX_OBS;
    localparam int FBITS        = DEF_FRAC_BITS;
    localparam logic [FUNC_W-1:0] FN_UNUSED_LO  = 3'd5;
    localparam logic [FUNC_W-1:0] FN_UNUSED_MID = 3'd6;
    localparam logic [FUNC_W-1:0] FN_UNUSED_HI  = 3'd7;

    // Predicts status and read data for each accepted request
    class jacobian_scoreboard;
        longint      jac[NUM_DIMS*NUM_OBS];
        longint      stp[NUM_DIMS];
        longint      rdelta[NUM_OBS];
        longint      corr[NUM_OBS];
        bit          jac_set[NUM_DIMS*NUM_OBS];
        bit          stp_set[NUM_DIMS];
        bit          rdelta_set[NUM_OBS];
        int unsigned dims_reg = 8;
        int unsigned obs_reg  = 64;
        status_t     want_status[$];
        logic [31:0] want_read[$];
        int          errors, requests, updates, sat_seen, zero_seen;

        function int unsigned eff_dims();
            if (dims_reg < 1) return 1;
            return (dims_reg > NUM_DIMS) ? NUM_DIMS : dims_reg;
        endfunction

        function int unsigned eff_obs();
            if (obs_reg < 1) return 1;
            return (obs_reg > NUM_OBS) ? NUM_OBS : obs_reg;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_DIMS) dims_reg = data & 4'hF;
            else obs_reg = data;
        endfunction

        function longint unsigned magn(longint v);
            return (v < 0) ? -v : v;
        endfunction

        function longint clamp(longint v, inout bit sat);
            if (v > 64'sd2147483647) begin sat = 1; return 64'sd2147483647; end
            if (v < -64'sd2147483648) begin sat = 1; return -64'sd2147483648; end
            return v;
        endfunction

        // every store entry an update would touch has been loaded
        function bit update_ready();
            for (int i = 0; i < eff_dims(); i++) begin
                if (!stp_set[i]) return 0;
                for (int j = 0; j < eff_obs(); j++)
                    if (!jac_set[i*NUM_OBS+j]) return 0;
            end
            for (int j = 0; j < eff_obs(); j++)
                if (!rdelta_set[j]) return 0;
            return 1;
        endfunction

        function bit read_safe(int unsigned d, int unsigned o);
            if (d >= eff_dims() || o >= eff_obs()) return 1;
            return jac_set[d*NUM_OBS+o];
        endfunction

        function status_t rank_one_update();
            longint unsigned s = 0, q;
            longint jh, inc, u, h;
            bit sat = 0;
            int unsigned nd = eff_dims(), no = eff_obs();
            for (int i = 0; i < nd; i++)
                s += (magn(stp[i]) * magn(stp[i])) >> FBITS;
            if (s == 0) return ST_ZERO;
            for (int j = 0; j < no; j++) begin
                jh = 0;
                for (int i = 0; i < nd; i++) begin
                    q = (magn(jac[i*NUM_OBS+j]) * magn(stp[i])) >> FBITS;
                    jh += ((jac[i*NUM_OBS+j] < 0) != (stp[i] < 0)) ? -longint'(q) : longint'(q);
                end
                corr[j] = clamp(rdelta[j] - jh, sat);
            end
            for (int i = 0; i < nd; i++)
                for (int j = 0; j < no; j++) begin
                    u = corr[j];
                    h = stp[i];
                    q = (magn(u) * magn(h)) / s;
                    inc = ((u < 0) != (h < 0)) ? -longint'(q) : longint'(q);
                    jac[i*NUM_OBS+j] = clamp(jac[i*NUM_OBS+j] + inc, sat);
                end
            return sat ? ST_SAT : ST_OK;
        endfunction

        function void note(logic [2:0] fn, logic [2:0] d, logic [5:0] o,
                           logic signed [31:0] jv, logic signed [31:0] sv,
                           logic signed [31:0] nr, logic signed [31:0] orr);
            bit      dok = d < eff_dims(), ook = o < eff_obs(), sat = 0;
            status_t st = ST_OK;
            longint  rd = 0;
            requests++;
            case (fn)
                FN_LOAD_JAC:
                    if (dok && ook) begin
                        jac[d*NUM_OBS+o] = jv;
                        jac_set[d*NUM_OBS+o] = 1;
                    end else st = ST_RANGE;
                FN_LOAD_STEP:
                    if (dok) begin
                        stp[d] = sv;
                        stp_set[d] = 1;
                    end else st = ST_RANGE;
                FN_LOAD_RES:
                    if (ook) begin
                        rdelta[o] = clamp(longint'(nr) - longint'(orr), sat);
                        rdelta_set[o] = 1;
                        if (sat) st = ST_SAT;
                    end else st = ST_RANGE;
                FN_UPDATE: begin
                    updates++;
                    st = rank_one_update();
                end
                FN_READ_JAC:
                    if (dok && ook) rd = jac[d*NUM_OBS+o];
                    else st = ST_RANGE;
                default: ;
            endcase
            if (st == ST_SAT) sat_seen++;
            if (st == ST_ZERO) zero_seen++;
            want_status = {want_status, st};
            want_read = {want_read, rd[31:0]};
        endfunction

        function void check(logic [1:0] st, logic [31:0] rv);
            if (want_status.size() == 0) begin
                $error("result with no request outstanding: status %0d read %h", st, rv);
                errors++;
                return;
            end
            if (st !== want_status[0]) begin
                $error("status: expected %0d, got %0d", want_status[0], st);
                errors++;
            end
            if (rv !== want_read[0]) begin
                $error("read_value: expected %h, got %h", want_read[0], rv);
                errors++;
            end
            void'(want_status.pop_front());
            void'(want_read.pop_front());
        endfunction
    endclass

    logic clk = 0, rst_n = 0, start = 0, cfg_write = 0;
    logic busy, done;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic [FUNC_W-1:0]     func = '0;
    logic [DIM_IDX_W-1:0]  dim_index = '0;
    logic [OBS_IDX_W-1:0]  obs_index = '0;
    logic signed [31:0]    jacobian_value = '0, step_value = '0;
    logic signed [31:0]    new_residual = '0, old_residual = '0;
    logic [1:0]            status;
    logic signed [31:0]    read_value;
    int                    cycles = 0;
    bit                    gaps_on = 1;
    jacobian_scoreboard    sb = new();

    broyden_jacobian_update i_dut (
        .clk, .rst_n, .start, .busy, .done, .cfg_write, .cfg_index, .cfg_data,
        .func, .dim_index, .obs_index, .jacobian_value, .step_value,
        .new_residual, .old_residual, .status, .read_value
    );

    always #10 clk = ~clk;

    // result monitor and run limit
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (rst_n && done) sb.check(status, read_value);
        if (cycles > LIMIT_CYCLES) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // data mix: extremes, full range, mostly moderate values
    function automatic logic signed [31:0] pick_value(bit tiny_ok);
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 32'sh7FFF_FFFF;
            2: return 32'sh8000_0000;
            3: return $urandom;
            4: return tiny_ok ? $signed($urandom_range(0, 511)) - 256 : $urandom;
            default: return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
        endcase
    endfunction

    // one request: optional gap, then hold start until accepted
    task automatic send_request(logic [2:0] fn, logic [2:0] d, logic [5:0] o,
                                logic signed [31:0] jv, logic signed [31:0] sv,
                                logic signed [31:0] nr, logic signed [31:0] orr);
        if (gaps_on && $urandom_range(0, 99) < 31) begin
            start <= 0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start <= 1;
        func <= fn; dim_index <= d; obs_index <= o;
        jacobian_value <= jv; step_value <= sv;
        new_residual <= nr; old_residual <= orr;
        do @(posedge clk); while (busy);
        sb.note(fn, d, o, jv, sv, nr, orr);
    endtask

    // drain outstanding requests, then write both registers
    task automatic set_shape(logic [CFG_DATA_W-1:0] dims, logic [CFG_DATA_W-1:0] obs);
        start <= 0;
        while (sb.want_status.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
        cfg_write <= 1; cfg_index <= CFG_DIMS; cfg_data <= dims;
        @(posedge clk);
        sb.write_reg(CFG_DIMS, dims);
        cfg_index <= CFG_OBS; cfg_data <= obs;
        @(posedge clk);
        sb.write_reg(CFG_OBS, obs);
        cfg_write <= 0;
    endtask

    // load every in-use entry not yet written
    task automatic fill_stores();
        for (int i = 0; i < sb.eff_dims(); i++) begin
            if (!sb.stp_set[i])
                send_request(FN_LOAD_STEP, DIM_IDX_W'(i), 0, 0, pick_value(1), 0, 0);
            for (int j = 0; j < sb.eff_obs(); j++)
                if (!sb.jac_set[i*NUM_OBS+j])
                    send_request(FN_LOAD_JAC, DIM_IDX_W'(i), OBS_IDX_W'(j),
                                 pick_value(0), 0, 0, 0);
        end
        for (int j = 0; j < sb.eff_obs(); j++)
            if (!sb.rdelta_set[j])
                send_request(FN_LOAD_RES, 0, OBS_IDX_W'(j), 0, 0,
                             pick_value(0), pick_value(0));
    endtask

    task automatic random_requests(int count);
        logic [2:0] fn, d;
        logic [5:0] o;
        int         r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            fn = (r < 25) ? FN_LOAD_JAC : (r < 37) ? FN_LOAD_STEP : (r < 55) ? FN_LOAD_RES :
                 (r < 65) ? FN_UPDATE : (r < 95) ? FN_READ_JAC :
                 FUNC_W'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
            if ($urandom_range(0, 4) == 0) begin
                d = DIM_IDX_W'($urandom);
                o = OBS_IDX_W'($urandom);
            end else begin
                d = DIM_IDX_W'($urandom_range(0, sb.eff_dims() - 1));
                o = OBS_IDX_W'($urandom_range(0, sb.eff_obs() - 1));
            end
            // never touch an entry that was not written
            if (fn == FN_READ_JAC && !sb.read_safe(d, o)) fn = FN_LOAD_JAC;
            if (fn == FN_UPDATE && !sb.update_ready()) fn = FN_LOAD_RES;
            send_request(fn, d, o, pick_value(0), pick_value(1), pick_value(0), pick_value(0));
        end
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: corners at reset shape, unused codes, residual saturation
        send_request(FN_LOAD_JAC, 7, 63, 32'sh7FFF_FFFF, 0, 0, 0);
        send_request(FN_READ_JAC, 7, 63, 0, 0, 0, 0);
        send_request(FN_LOAD_JAC, 0, 0, 32'sh8000_0000, 0, 0, 0);
        send_request(FN_READ_JAC, 0, 0, 0, 0, 0, 0);
        send_request(FN_LOAD_STEP, 7, 0, 0, 32'sh8000_0000, 0, 0);
        send_request(FN_LOAD_RES, 0, 63, 0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_request(FN_LOAD_RES, 0, 0, 0, 0, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_request(FN_LOAD_RES, 0, 1, 0, 0, 32'sh0001_0000, -32'sh0002_0000);
        send_request(FN_UNUSED_LO, 7, 63, -1, -1, -1, -1);
        send_request(FN_UNUSED_MID, 0, 0, 0, 0, 0, 0);
        send_request(FN_UNUSED_HI, 3, 5, 0, 0, 0, 0);

        // small shape: out-of-range, zero step, tiny step, then full update
        set_shape(2, 4);
        send_request(FN_LOAD_JAC, 2, 0, 1, 0, 0, 0);
        send_request(FN_LOAD_STEP, 5, 0, 0, 1, 0, 0);
        send_request(FN_LOAD_RES, 0, 4, 0, 0, 1, 0);
        send_request(FN_READ_JAC, 0, 63, 0, 0, 0, 0);
        fill_stores();
        send_request(FN_LOAD_STEP, 0, 0, 0, 0, 0, 0);
        send_request(FN_LOAD_STEP, 1, 0, 0, 0, 0, 0);
        send_request(FN_UPDATE, 0, 0, 0, 0, 0, 0);
        send_request(FN_LOAD_STEP, 1, 0, 0, -32'sd255, 0, 0);
        send_request(FN_UPDATE, 0, 0, 0, 0, 0, 0);
        send_request(FN_LOAD_STEP, 0, 0, 0, 32'sh0001_0000, 0, 0);
        send_request(FN_LOAD_RES, 0, 2, 0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_request(FN_UPDATE, 0, 0, 0, 0, 0, 0);
        send_request(FN_READ_JAC, 1, 2, 0, 0, 0, 0);
        random_requests(40);

        // sweep of shapes, extremes and clamped register values included
        set_shape(1, 1);    fill_stores(); random_requests(20);
        set_shape(0, 0);    fill_stores(); random_requests(10);
        set_shape(8, 2);    fill_stores(); random_requests(30);
        set_shape(15, 3);   fill_stores(); random_requests(20);
        set_shape(1, 64);   fill_stores(); random_requests(25);
        set_shape(3, 127);  fill_stores(); random_requests(15);

        // back-to-back stretch with no sender gaps
        set_shape(4, 8);
        gaps_on = 0;
        fill_stores();
        random_requests(65);
        gaps_on = 1;

        start <= 0;
        while (sb.want_status.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        $display("tb: %0d requests over nine array shapes, %0d rank-one updates",
                 sb.requests, sb.updates);
        $display("tb: %0d saturated and %0d zero-length-step results checked",
                 sb.sat_seen, sb.zero_seen);
        if (sb.errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule
